// File: src/aeg_pkg.sv
// ----------------------------------------------------------------------------
// aeg_pkg
// Shared types for the Accept-Encoding gzip check: byte classification that
// travels from the front end through the queue to the parser back end.
// ----------------------------------------------------------------------------
package aeg_pkg;

   // one header byte, already decoded into the flags the parser needs
   typedef struct packed {
      logic       last;
      logic       comma;
      logic       semi;
      logic       equal;
      logic       blank;
      logic       star;
      logic       lc_g;
      logic       lc_z;
      logic       lc_i;
      logic       lc_p;
      logic       lc_q;
      logic       one;
      logic       zero;
      logic       dot;
      logic       digit;
      logic [3:0] digit_val;
   } byte_class_type;

   localparam int unsigned ClassWidth = $bits(byte_class_type);

   localparam logic [9:0] FullQuality = 10'd1000;

endpackage

// File: src/aeg_front.sv
// ----------------------------------------------------------------------------
// aeg_front
// Input stage: takes header bytes and registers their classification.
// ----------------------------------------------------------------------------
module aeg_front
   import aeg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   input  logic [7:0]     req_header_byte,
   input  logic           req_last_byte,
   output logic           req_full,
   output logic           cls_valid,
   output byte_class_type cls_item,
   input  logic           cls_taken
);

   logic           valid_ff;
   logic           valid_in;
   byte_class_type item_ff;
   byte_class_type item_in;
   logic [7:0]     folded;
   logic           load;

   assign req_full  = valid_ff && !cls_taken;
   assign load      = req_push && !req_full;
   assign cls_valid = valid_ff;
   assign cls_item  = item_ff;

   always_comb begin
      // only A..Z fold to lower case
      if (req_header_byte >= 8'h41 && req_header_byte <= 8'h5a) begin
         folded = req_header_byte + 8'h20;
      end else begin
         folded = req_header_byte;
      end
      item_in.last      = req_last_byte;
      item_in.comma     = (req_header_byte == 8'h2c);
      item_in.semi      = (req_header_byte == 8'h3b);
      item_in.equal     = (req_header_byte == 8'h3d);
      item_in.blank     = (req_header_byte == 8'h20) || (req_header_byte == 8'h09);
      item_in.star      = (req_header_byte == 8'h2a);
      item_in.lc_g      = (folded == 8'h67);
      item_in.lc_z      = (folded == 8'h7a);
      item_in.lc_i      = (folded == 8'h69);
      item_in.lc_p      = (folded == 8'h70);
      item_in.lc_q      = (folded == 8'h71);
      item_in.one       = (req_header_byte == 8'h31);
      item_in.zero      = (req_header_byte == 8'h30);
      item_in.dot       = (req_header_byte == 8'h2e);
      item_in.digit     = (req_header_byte >= 8'h30) && (req_header_byte <= 8'h39);
      item_in.digit_val = req_header_byte[3:0];
      valid_in          = load || (valid_ff && !cls_taken);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: src/aeg_queue.sv
// ----------------------------------------------------------------------------
// aeg_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module aeg_queue
   import aeg_pkg::*;
#(
   parameter int unsigned DEPTH = 2
)
(
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_valid,
   input  byte_class_type wr_item,
   output logic           wr_taken,
   output logic           rd_valid,
   output byte_class_type rd_item,
   input  logic           rd_taken
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastSlot = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCount = CntWidth'(DEPTH);

   byte_class_type        slot_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_in;
   logic [CntWidth-1:0]   count_ff;
   logic [CntWidth-1:0]   count_in;
   logic                  do_wr;
   logic                  do_rd;

   assign wr_taken = wr_valid && (count_ff != FullCount);
   assign do_wr    = wr_taken;
   assign rd_valid = (count_ff != '0);
   assign do_rd    = rd_valid && rd_taken;
   assign rd_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// File: src/aeg_back.sv
// ----------------------------------------------------------------------------
// aeg_back
// Parser back end: tracks element, parameter and q value state per byte,
// keeps the best gzip and wildcard qualities and holds the result register.
// ----------------------------------------------------------------------------
module aeg_back
   import aeg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               cls_valid,
   input  byte_class_type     cls_item,
   output logic               cls_taken,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_accepts_gzip,
   output logic signed [10:0] rsp_gzip_quality,
   output logic signed [10:0] rsp_wildcard_quality
);

   localparam logic [1:0] PhCoding = 2'd0;
   localparam logic [1:0] PhName   = 2'd1;
   localparam logic [1:0] PhValue  = 2'd2;
   localparam logic [1:0] PhSkip   = 2'd3;

   localparam logic [2:0] CmEmpty = 3'd0;
   localparam logic [2:0] CmGzip  = 3'd4;
   localparam logic [2:0] CmStar  = 3'd5;
   localparam logic [2:0] CmNone  = 3'd6;

   localparam logic [1:0] NmEmpty = 2'd0;
   localparam logic [1:0] NmQ     = 2'd1;
   localparam logic [1:0] NmOther = 2'd2;

   localparam logic [1:0] QsEmpty = 2'd0;
   localparam logic [1:0] QsValid = 2'd1;
   localparam logic [1:0] QsBad   = 2'd2;

   localparam logic signed [10:0] NoneSeen = -11'sd1;

   logic [1:0]         phase_ff,  phase_in;
   logic [2:0]         coding_ff, coding_in;
   logic [1:0]         name_ff,   name_in;
   logic               space_ff,  space_in;
   logic [9:0]         accum_ff,  accum_in;
   logic [2:0]         chars_ff,  chars_in;
   logic [1:0]         status_ff, status_in;
   logic [9:0]         elemq_ff,  elemq_in;
   logic signed [10:0] gzip_ff,   gzip_in;
   logic signed [10:0] wild_ff,   wild_in;
   logic               out_valid_ff, out_valid_in;
   logic               accepts_ff, accepts_in;
   logic signed [10:0] out_gzip_ff;
   logic signed [10:0] out_wild_ff;
   logic               step;
   logic               match_next;
   logic               blank_empty;
   logic [9:0]         scaled;

   assign cls_taken = cls_valid && (!cls_item.last || !out_valid_ff || rsp_pop);
   assign step      = cls_taken;

   assign rsp_empty            = !out_valid_ff;
   assign rsp_accepts_gzip     = accepts_ff;
   assign rsp_gzip_quality     = out_gzip_ff;
   assign rsp_wildcard_quality = out_wild_ff;

   always_comb begin
      phase_in     = phase_ff;
      coding_in    = coding_ff;
      name_in      = name_ff;
      space_in     = space_ff;
      accum_in     = accum_ff;
      chars_in     = chars_ff;
      status_in    = status_ff;
      elemq_in     = elemq_ff;
      gzip_in      = gzip_ff;
      wild_in      = wild_ff;
      accepts_in   = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;

      unique case (coding_ff)
         3'd0:    match_next = cls_item.lc_g;
         3'd1:    match_next = cls_item.lc_z;
         3'd2:    match_next = cls_item.lc_i;
         3'd3:    match_next = cls_item.lc_p;
         default: match_next = 1'b0;
      endcase

      unique case (phase_ff)
         PhCoding: blank_empty = (coding_ff == CmEmpty);
         PhName:   blank_empty = (name_ff == NmEmpty);
         default:  blank_empty = (status_ff == QsEmpty);
      endcase

      unique case (chars_ff)
         3'd2:    scaled = 10'(cls_item.digit_val) * 10'd100;
         3'd3:    scaled = 10'(cls_item.digit_val) * 10'd10;
         default: scaled = 10'(cls_item.digit_val);
      endcase

      // per-byte update
      if (cls_item.comma || cls_item.semi) begin
         if (phase_in == PhValue) begin
            elemq_in = (status_in == QsValid) ? accum_in : '0;
         end
         if (cls_item.comma) begin
            if (coding_in == CmGzip) begin
               if ($signed({1'b0, elemq_in}) > gzip_in) gzip_in = $signed({1'b0, elemq_in});
            end else if (coding_in == CmStar) begin
               if ($signed({1'b0, elemq_in}) > wild_in) wild_in = $signed({1'b0, elemq_in});
            end
            phase_in  = PhCoding;
            coding_in = CmEmpty;
            elemq_in  = FullQuality;
         end else begin
            phase_in = PhName;
         end
         name_in   = NmEmpty;
         space_in  = 1'b0;
         accum_in  = '0;
         chars_in  = '0;
         status_in = QsEmpty;
      end else if (phase_ff == PhSkip) begin
         // rest of an ignored parameter
      end else if (phase_ff == PhName && cls_item.equal) begin
         phase_in = (name_ff == NmQ) ? PhValue : PhSkip;
         space_in = 1'b0;
      end else if (cls_item.blank) begin
         if (!blank_empty) space_in = 1'b1;
      end else if (phase_ff == PhCoding) begin
         if (coding_ff == CmNone) begin
         end else if (space_ff) begin
            coding_in = CmNone;
         end else if (coding_ff < CmGzip && match_next) begin
            coding_in = coding_ff + 3'd1;
         end else if (coding_ff == CmEmpty && cls_item.star) begin
            coding_in = CmStar;
         end else begin
            coding_in = CmNone;
         end
      end else if (phase_ff == PhName) begin
         if (name_ff == NmEmpty && !space_ff && cls_item.lc_q) name_in = NmQ;
         else name_in = NmOther;
      end else begin
         // q value character
         if (status_ff == QsBad) begin
         end else if (space_ff || chars_ff >= 3'd5) begin
            status_in = QsBad;
         end else if (chars_ff == 3'd0) begin
            if (cls_item.one || cls_item.zero) begin
               accum_in  = cls_item.one ? FullQuality : '0;
               status_in = QsValid;
               chars_in  = chars_ff + 3'd1;
            end else begin
               status_in = QsBad;
            end
         end else if (chars_ff == 3'd1) begin
            if (cls_item.dot) begin
               status_in = QsValid;
               chars_in  = chars_ff + 3'd1;
            end else begin
               status_in = QsBad;
            end
         end else if (accum_ff == FullQuality) begin
            if (cls_item.zero) begin
               status_in = QsValid;
               chars_in  = chars_ff + 3'd1;
            end else begin
               status_in = QsBad;
            end
         end else if (cls_item.digit) begin
            accum_in  = accum_ff + scaled;
            status_in = QsValid;
            chars_in  = chars_ff + 3'd1;
         end else begin
            status_in = QsBad;
         end
      end

      // final byte closes the open element and publishes the result
      if (cls_item.last) begin
         if (phase_in == PhValue) begin
            elemq_in = (status_in == QsValid) ? accum_in : '0;
         end
         if (coding_in == CmGzip) begin
            if ($signed({1'b0, elemq_in}) > gzip_in) gzip_in = $signed({1'b0, elemq_in});
         end else if (coding_in == CmStar) begin
            if ($signed({1'b0, elemq_in}) > wild_in) wild_in = $signed({1'b0, elemq_in});
         end
         accepts_in   = (gzip_in >= 0) ? (gzip_in > 0) : (wild_in > 0);
         out_valid_in = 1'b1;
         phase_in     = PhCoding;
         coding_in    = CmEmpty;
         name_in      = NmEmpty;
         space_in     = 1'b0;
         accum_in     = '0;
         chars_in     = '0;
         status_in    = QsEmpty;
         elemq_in     = FullQuality;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhCoding;
         coding_ff    <= CmEmpty;
         name_ff      <= NmEmpty;
         space_ff     <= 1'b0;
         accum_ff     <= '0;
         chars_ff     <= '0;
         status_ff    <= QsEmpty;
         elemq_ff     <= FullQuality;
         gzip_ff      <= NoneSeen;
         wild_ff      <= NoneSeen;
         out_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff  <= phase_in;
            coding_ff <= coding_in;
            name_ff   <= name_in;
            space_ff  <= space_in;
            accum_ff  <= accum_in;
            chars_ff  <= chars_in;
            status_ff <= status_in;
            elemq_ff  <= elemq_in;
            if (cls_item.last) begin
               gzip_ff <= NoneSeen;
               wild_ff <= NoneSeen;
            end else begin
               gzip_ff <= gzip_in;
               wild_ff <= wild_in;
            end
            out_valid_ff <= cls_item.last ? 1'b1 : out_valid_in;
         end else begin
            out_valid_ff <= out_valid_ff && !rsp_pop;
         end
      end
      if (step && cls_item.last) begin
         accepts_ff  <= accepts_in;
         out_gzip_ff <= gzip_in;
         out_wild_ff <= wild_in;
      end
   end

endmodule

// File: src/accept_encoding_gzip_check_top.sv
// ----------------------------------------------------------------------------
// accept_encoding_gzip_check_top
// Streaming Accept-Encoding check that reports whether gzip is acceptable.
// ----------------------------------------------------------------------------
// Takes one header byte per clock while req_full is low, with no gaps needed
// between headers. A byte is classified in the front register, waits in a
// QUEUE_DEPTH-entry queue and is parsed by the back end; the result is
// registered in the back end's result register and stays on the result ports
// until it is popped. The back end stalls only when a header ends
// while the previous result has not yet been popped.
module accept_encoding_gzip_check_top
   import aeg_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_header_byte,
   input  logic               req_last_byte,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_accepts_gzip,
   output logic signed [10:0] rsp_gzip_quality,
   output logic signed [10:0] rsp_wildcard_quality
);

   logic           front_valid;
   byte_class_type front_item;
   logic           front_taken;
   logic           queue_valid;
   byte_class_type queue_item;
   logic           queue_taken;

   aeg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_header_byte (req_header_byte),
      .req_last_byte   (req_last_byte),
      .req_full        (req_full),
      .cls_valid       (front_valid),
      .cls_item        (front_item),
      .cls_taken       (front_taken)
   );

   aeg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_item  (front_item),
      .wr_taken (front_taken),
      .rd_valid (queue_valid),
      .rd_item  (queue_item),
      .rd_taken (queue_taken)
   );

   aeg_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cls_valid            (queue_valid),
      .cls_item             (queue_item),
      .cls_taken            (queue_taken),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_accepts_gzip     (rsp_accepts_gzip),
      .rsp_gzip_quality     (rsp_gzip_quality),
      .rsp_wildcard_quality (rsp_wildcard_quality)
   );

endmodule

// File: tb/accept_encoding_gzip_check_checker.sv
// ----------------------------------------------------------------------------
// accept_encoding_gzip_check_checker
// Watches both queue-style channels of the gzip check. Every accepted header
// byte runs through a local parser model. A byte that ends a header queues
// the expected verdict. Every popped result is compared field by field with
// the oldest queued verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module accept_encoding_gzip_check_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic [7:0]         req_header_byte,
   input  logic               req_last_byte,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic               rsp_accepts_gzip,
   input  logic signed [10:0] rsp_gzip_quality,
   input  logic signed [10:0] rsp_wildcard_quality,
   output int                 mismatch_count,
   output int                 verdicts_waiting
);

   typedef enum logic [1:0] {PH_CODING, PH_NAME, PH_VALUE, PH_SKIP} phase_type;
   typedef enum logic [2:0] {
      CD_EMPTY, CD_G, CD_GZ, CD_GZI, CD_GZIP, CD_STAR, CD_NONE
   } coding_type;
   typedef enum logic [1:0] {NM_EMPTY, NM_Q, NM_OTHER} name_type;
   typedef enum logic [1:0] {QV_EMPTY, QV_OK, QV_BAD} qval_type;

   typedef struct {
      logic               accepts;
      logic signed [10:0] gzip_q;
      logic signed [10:0] star_q;
   } verdict_type;

   localparam int         FullQ    = 1000;
   localparam logic [31:0] GzipWord = "gzip";
   localparam logic [7:0] ChComma  = ",";
   localparam logic [7:0] ChSemi   = ";";
   localparam logic [7:0] ChEqual  = "=";
   localparam logic [7:0] ChSpace  = " ";
   localparam logic [7:0] ChTab    = 8'h09;
   localparam logic [7:0] ChStar   = "*";

   phase_type   phase;
   coding_type  coding;
   name_type    pname;
   logic        gap_inside;
   int          q_accum;
   int          q_chars;
   qval_type    q_stat;
   int          elem_q;
   int          best_gzip;
   int          best_star;
   int          errs;
   verdict_type verdicts [$];

   function automatic logic [7:0] fold(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic void new_param();
      phase = PH_NAME;
      pname = NM_EMPTY;
      gap_inside = 1'b0;
      q_accum = 0;
      q_chars = 0;
      q_stat = QV_EMPTY;
   endfunction

   function automatic void new_element();
      new_param();
      phase = PH_CODING;
      coding = CD_EMPTY;
      elem_q = FullQ;
   endfunction

   function automatic void close_param();
      if (phase == PH_VALUE) elem_q = (q_stat == QV_OK) ? q_accum : 0;
   endfunction

   function automatic void close_element();
      close_param();
      if (coding == CD_GZIP) begin
         if (elem_q > best_gzip) best_gzip = elem_q;
      end else if (coding == CD_STAR) begin
         if (elem_q > best_star) best_star = elem_q;
      end
      new_element();
   endfunction

   function automatic void clear_parser();
      new_element();
      best_gzip = -1;
      best_star = -1;
   endfunction

   function automatic void coding_byte(logic [7:0] c);
      if (coding == CD_NONE) return;
      if (gap_inside) begin
         coding = CD_NONE;
         return;
      end
      if (coding < CD_GZIP && fold(c) == GzipWord[8 * (3 - int'(coding)) +: 8])
         coding = coding_type'(coding + 1);
      else if (coding == CD_EMPTY && c == ChStar)
         coding = CD_STAR;
      else
         coding = CD_NONE;
   endfunction

   function automatic void name_byte(logic [7:0] c);
      if (pname == NM_EMPTY && !gap_inside && fold(c) == "q")
         pname = NM_Q;
      else
         pname = NM_OTHER;
   endfunction

   function automatic void value_byte(logic [7:0] c);
      int scale;
      if (q_stat == QV_BAD) return;
      if (gap_inside || q_chars >= 5) begin
         q_stat = QV_BAD;
         return;
      end
      if (q_chars == 0) begin
         if (c == "1") q_accum = FullQ;
         else if (c == "0") q_accum = 0;
         else begin
            q_stat = QV_BAD;
            return;
         end
      end else if (q_chars == 1) begin
         if (c != ".") begin
            q_stat = QV_BAD;
            return;
         end
      end else if (q_accum == FullQ) begin
         // only trailing zeros may follow "1."
         if (c != "0") begin
            q_stat = QV_BAD;
            return;
         end
      end else begin
         if (c < "0" || c > "9") begin
            q_stat = QV_BAD;
            return;
         end
         scale = (q_chars == 2) ? 100 : (q_chars == 3) ? 10 : 1;
         q_accum += int'(c - 8'd48) * scale;
      end
      q_stat = QV_OK;
      q_chars++;
   endfunction

   function automatic void absorb_byte(logic [7:0] c);
      logic blank;
      logic empty;
      blank = (c == ChSpace || c == ChTab);
      if (c == ChComma) begin
         close_element();
         return;
      end
      if (c == ChSemi) begin
         close_param();
         new_param();
         return;
      end
      if (phase == PH_SKIP) return;
      if (phase == PH_NAME && c == ChEqual) begin
         phase = (pname == NM_Q) ? PH_VALUE : PH_SKIP;
         gap_inside = 1'b0;
         return;
      end
      if (blank) begin
         // blanks before a token's first character are trimmed
         case (phase)
            PH_CODING: empty = (coding == CD_EMPTY);
            PH_NAME:   empty = (pname == NM_EMPTY);
            default:   empty = (q_stat == QV_EMPTY);
         endcase
         if (!empty) gap_inside = 1'b1;
         return;
      end
      case (phase)
         PH_CODING: coding_byte(c);
         PH_NAME:   name_byte(c);
         default:   value_byte(c);
      endcase
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         clear_parser();
         verdicts.delete();
         errs = 0;
         mismatch_count <= 0;
         verdicts_waiting <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (verdicts.size() == 0) begin
               $display("%0t: unexpected result accepts=%0b gzip=%0d wildcard=%0d", $time,
                        rsp_accepts_gzip, rsp_gzip_quality, rsp_wildcard_quality);
               errs++;
            end else begin
               want = verdicts.pop_front();
               if (rsp_accepts_gzip !== want.accepts) begin
                  $display("%0t: accepts_gzip expected %0b actual %0b", $time,
                           want.accepts, rsp_accepts_gzip);
                  errs++;
               end
               if (rsp_gzip_quality !== want.gzip_q) begin
                  $display("%0t: gzip_quality expected %0d actual %0d", $time,
                           want.gzip_q, rsp_gzip_quality);
                  errs++;
               end
               if (rsp_wildcard_quality !== want.star_q) begin
                  $display("%0t: wildcard_quality expected %0d actual %0d", $time,
                           want.star_q, rsp_wildcard_quality);
                  errs++;
               end
            end
         end
         if (req_push && !req_full) begin
            absorb_byte(req_header_byte);
            if (req_last_byte) begin
               close_element();
               want.accepts = (best_gzip >= 0) ? (best_gzip > 0) : (best_star > 0);
               want.gzip_q = 11'(best_gzip);
               want.star_q = 11'(best_star);
               verdicts.push_back(want);
               clear_parser();
            end
         end
         mismatch_count <= errs;
         verdicts_waiting <= verdicts.size();
      end
   end

endmodule

// File: tb/tb_accept_encoding_gzip_check_top.sv
// ----------------------------------------------------------------------------
// tb_accept_encoding_gzip_check_top
// Feeds Accept-Encoding header values byte by byte into the gzip check with
// random gaps and result stalls. A short directed set comes first, then
// random headers, mostly well formed with random content and some noise or
// damage. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_accept_encoding_gzip_check_top;

   localparam int CycleLimit = 500000;
   localparam int ByteTarget = 1500;
   localparam int TailCycles = 20;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [7:0]         req_header_byte = 8'h00;
   logic               req_last_byte = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic               rsp_accepts_gzip;
   logic signed [10:0] rsp_gzip_quality;
   logic signed [10:0] rsp_wildcard_quality;

   int                 mismatch_count;
   int                 verdicts_waiting;
   int                 cycle_count = 0;
   int                 bytes_sent = 0;
   int                 pop_hold = 0;
   logic               burst = 1'b0;
   logic               calm = 1'b0;
   logic [7:0]         hdr [$];

   accept_encoding_gzip_check_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_header_byte      (req_header_byte),
      .req_last_byte        (req_last_byte),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_accepts_gzip     (rsp_accepts_gzip),
      .rsp_gzip_quality     (rsp_gzip_quality),
      .rsp_wildcard_quality (rsp_wildcard_quality)
   );

   accept_encoding_gzip_check_checker verdict_check (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_header_byte      (req_header_byte),
      .req_last_byte        (req_last_byte),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_accepts_gzip     (rsp_accepts_gzip),
      .rsp_gzip_quality     (rsp_gzip_quality),
      .rsp_wildcard_quality (rsp_wildcard_quality),
      .mismatch_count       (mismatch_count),
      .verdicts_waiting     (verdicts_waiting)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // mostly short idle stretches, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 40);
   endfunction

   function automatic int send_gap();
      if (burst || $urandom_range(0, 99) < 55) return 0;
      return idle_len();
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_hold <= 0;
      end else if (pop_hold != 0) begin
         rsp_pop <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else begin
         rsp_pop <= 1'b1;
         if (!calm && $urandom_range(0, 99) < 20) pop_hold <= idle_len();
      end
   end

   // one of two texts at random
   function automatic string pick(string a, string b);
      if ($urandom_range(0, 1)) return a;
      return b;
   endfunction

   function automatic void put_text(string s);
      foreach (s[i]) hdr.push_back(s[i]);
   endfunction

   // random letter case
   function automatic void put_word(string s);
      logic [7:0] c;
      foreach (s[i]) begin
         c = s[i];
         if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
         hdr.push_back(c);
      end
   endfunction

   function automatic void put_pad();
      if ($urandom_range(0, 99) < 25) begin
         repeat ($urandom_range(1, 2)) hdr.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
      end
   endfunction

   function automatic void put_coding();
      put_pad();
      case ($urandom_range(0, 11))
         0, 1, 2, 3: put_word("gzip");
         4, 5:       put_text("*");
         6:          put_word("gzi");
         7:          put_word(pick("gzipx", "x-gzip"));
         8:          put_word(pick("deflate", "br"));
         9:          put_word(pick("g zip", "gzip *"));
         10:         put_text(pick("**", "*g"));
         default:    ;
      endcase
      put_pad();
   endfunction

   function automatic void put_value();
      case ($urandom_range(0, 13))
         0: put_text("1");
         1: put_text("1.");
         2: begin
            put_text("1.");
            repeat ($urandom_range(1, 4)) put_text("0");
         end
         3: put_text("0");
         4, 5, 6, 7: begin
            put_text("0.");
            repeat ($urandom_range(0, 4)) hdr.push_back(8'(48 + $urandom_range(0, 9)));
         end
         8:  ;
         9:  put_text("0.1=2");
         10: put_text(pick("0 .5", "1 .0"));
         11: put_text(pick("1.5", "0.a"));
         12: hdr.push_back(8'($urandom_range(33, 126)));
         default: put_text(pick("2", "00.5"));
      endcase
   endfunction

   function automatic void put_param();
      put_text(";");
      put_pad();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: put_word("q");
         6: put_word("level");
         7: put_word("qq");
         8: put_word("q q");
         default: ;
      endcase
      put_pad();
      if ($urandom_range(0, 99) < 88) begin
         put_text("=");
         put_pad();
         put_value();
         put_pad();
      end
   endfunction

   function automatic void build_header();
      int         idx;
      logic [7:0] noise_set [9] = '{",", ";", "=", " ", 8'h09, "q", "Q", "*", "g"};
      hdr.delete();
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 1)) hdr.push_back(8'($urandom_range(0, 255)));
            else hdr.push_back(noise_set[$urandom_range(0, 8)]);
         end
      end else begin
         if ($urandom_range(0, 99) < 8) put_text(",");
         repeat ($urandom_range(1, 3)) begin
            if (hdr.size() != 0 && hdr[hdr.size() - 1] != ",") put_text(",");
            put_coding();
            repeat ($urandom_range(0, 2)) put_param();
         end
         if ($urandom_range(0, 99) < 10) put_text(",");
         // damaged header: drop or insert one byte
         if ($urandom_range(0, 99) < 10 && hdr.size() > 1) begin
            idx = $urandom_range(0, hdr.size() - 1);
            if ($urandom_range(0, 1)) hdr.delete(idx);
            else hdr.insert(idx, 8'($urandom_range(0, 255)));
         end
      end
      if (hdr.size() == 0) hdr.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic fin);
      int idle;
      idle = send_gap();
      if (idle > 0) begin
         req_push <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_push <= 1'b1;
      req_header_byte <= b;
      req_last_byte <= fin;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_header();
      foreach (hdr[i]) send_byte(hdr[i], i == hdr.size() - 1);
   endtask

   task automatic send_text(input string s);
      hdr.delete();
      put_text(s);
      send_header();
   endtask

   // hold the sender until every result has been popped
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (verdicts_waiting != 0) @(posedge clock);
   endtask

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[accept_encoding_gzip_check_top] ERROR");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // byte extremes, a bare comma, q forms, inner space in the coding
      hdr.delete();
      hdr.push_back(8'hff);
      send_header();
      hdr.delete();
      hdr.push_back(8'h00);
      send_header();
      send_text(",");
      send_text("gZIp;q=0");
      send_text("*;q=1.00");
      send_text("g zip");
      drain();

      while (bytes_sent < ByteTarget) begin
         build_header();
         send_header();
         if ($urandom_range(0, 99) < 10) burst = ~burst;
         if ($urandom_range(0, 99) < 10) calm <= ~calm;
         if ($urandom_range(0, 99) < 6) drain();
      end

      drain();
      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0 && verdicts_waiting == 0)
         $display("[accept_encoding_gzip_check_top] OK");
      else
         $display("[accept_encoding_gzip_check_top] ERROR");
      $finish;
   end

endmodule

// File: files.f
src/aeg_pkg.sv
src/aeg_front.sv
src/aeg_queue.sv
src/aeg_back.sv
src/accept_encoding_gzip_check_top.sv
tb/accept_encoding_gzip_check_checker.sv
tb/tb_accept_encoding_gzip_check_top.sv
